[rtl/core/fdl_pkg.sv]
package fdl_pkg;

    // Fixed field widths
    localparam int POS_W      = 24;
    localparam int IDX_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int GAIN_W     = 16;
    localparam int DAMP_W     = 9;
    localparam int FORCE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Pair arithmetic
    localparam int DIFF_W     = POS_W + 1;      // signed position difference
    localparam int D2_W       = 2 * DIFF_W;     // squared distance
    localparam int S_W        = DIFF_W;         // integer square root
    localparam int ROOT_STEPS = D2_W / 2;
    localparam int UNIT_BITS  = 16;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST     = 7'd0;
    localparam logic [GAIN_W-1:0]  REPULSION_GAIN_RST = 16'd200;
    localparam logic [DAMP_W-1:0]  DAMPING_GAIN_RST   = 9'd230;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT     = 2'd0,
        CFG_REPULSION_GAIN = 2'd1,
        CFG_DAMPING_GAIN   = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_STEP = 1'b1
    } req_type_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } pair_req_t;

endpackage

[rtl/core/fdl_pair_force.sv]
module fdl_pair_force #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fdl_pkg::pair_req_t                  req,
    input  logic [fdl_pkg::GAIN_W-1:0]          gain,
    output logic                                done,
    output logic signed [FRAC_BITS+18-1:0]      comp_x,
    output logic signed [FRAC_BITS+18-1:0]      comp_y
);
    import fdl_pkg::*;

    localparam int G_W    = GAIN_W + FRAC_BITS;
    localparam int Q_W    = 2 * FRAC_BITS + GAIN_W + 1;
    localparam int U_DV_W = DIFF_W + UNIT_BITS;
    localparam int DVD_W  = (U_DV_W > Q_W) ? U_DV_W : Q_W;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam int PROD_W = UNIT_BITS + 1 + G_W;
    localparam int MAG_W  = PROD_W - UNIT_BITS;
    localparam int COMP_W = FRAC_BITS + 18;
    localparam int LANES  = 3;

    typedef enum logic [8:0] {
        P_IDLE   = 9'b000000001,
        P_SQ     = 9'b000000010,
        P_SUM    = 9'b000000100,
        P_ROOT   = 9'b000001000,
        P_SFLOOR = 9'b000010000,
        P_DIV1   = 9'b000100000,
        P_DIV2   = 9'b001000000,
        P_MUL    = 9'b010000000,
        P_FIN    = 9'b100000000
    } pstate_t;

    pstate_t            state_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [DIFF_W-1:0]  magx_reg, magy_reg;
    logic               negx_reg, negy_reg;
    logic [D2_W-1:0]    sqx_reg, sqy_reg;
    logic [D2_W-1:0]    v_reg, res_reg, bit_reg;
    logic [S_W-1:0]     s_reg;
    logic [DVD_W-1:0]   dvd_reg [LANES];
    logic [S_W-1:0]     rem_reg [LANES];
    logic [G_W-1:0]     g_reg;
    logic [UNIT_BITS:0] ux_reg, uy_reg;
    logic [PROD_W-1:0]  prodx_reg, prody_reg;

    logic [D2_W-1:0]    sqx_full, sqy_full, root_try;
    logic [DVD_W-1:0]   dvd_step [LANES];
    logic [S_W-1:0]     rem_step [LANES];
    logic [S_W:0]       r2       [LANES];
    logic [S_W:0]       r2_sub   [LANES];
    logic [MAG_W-1:0]   pmx, pmy;

    assign sqx_full = D2_W'(magx_reg) * D2_W'(magx_reg);
    assign sqy_full = D2_W'(magy_reg) * D2_W'(magy_reg);
    assign root_try = res_reg + bit_reg;

    // one restoring-division bit per lane per cycle
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            r2[l]     = {rem_reg[l], dvd_reg[l][DVD_W-1]};
            r2_sub[l] = r2[l] - {1'b0, s_reg};
            if (r2[l] >= {1'b0, s_reg})
            begin
                rem_step[l] = r2_sub[l][S_W-1:0];
                dvd_step[l] = {dvd_reg[l][DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_step[l] = r2[l][S_W-1:0];
                dvd_step[l] = {dvd_reg[l][DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                P_IDLE:   if (req.start) state_reg <= P_SQ;
                P_SQ:     state_reg <= P_SUM;
                P_SUM:
                begin
                    state_reg <= P_ROOT;
                    cnt_reg   <= CNT_W'(ROOT_STEPS - 1);
                end
                P_ROOT:
                begin
                    if (cnt_reg == '0)
                        state_reg <= P_SFLOOR;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                P_SFLOOR:
                begin
                    state_reg <= P_DIV1;
                    cnt_reg   <= CNT_W'(DVD_W - 1);
                end
                P_DIV1:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= P_DIV2;
                        cnt_reg   <= CNT_W'(DVD_W - 1);
                    end
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                P_DIV2:
                begin
                    if (cnt_reg == '0)
                        state_reg <= P_MUL;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                P_MUL:    state_reg <= P_FIN;
                P_FIN:    state_reg <= P_IDLE;
                default:  state_reg <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            P_IDLE:
            begin
                if (req.start)
                begin
                    magx_reg <= req.dx[DIFF_W-1] ? DIFF_W'(-req.dx) : DIFF_W'(req.dx);
                    magy_reg <= req.dy[DIFF_W-1] ? DIFF_W'(-req.dy) : DIFF_W'(req.dy);
                    negx_reg <= req.dx[DIFF_W-1];
                    negy_reg <= req.dy[DIFF_W-1];
                end
            end
            P_SQ:
            begin
                sqx_reg <= sqx_full;
                sqy_reg <= sqy_full;
            end
            P_SUM:
            begin
                v_reg   <= sqx_reg + sqy_reg;
                res_reg <= '0;
                bit_reg <= D2_W'(1) << (D2_W - 2);
            end
            P_ROOT:
            begin
                if (v_reg >= root_try)
                begin
                    v_reg   <= v_reg - root_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            P_SFLOOR:
            begin
                // distance floored at 1.0
                if (res_reg < (D2_W'(1) << FRAC_BITS))
                    s_reg <= S_W'(1) << FRAC_BITS;
                else
                    s_reg <= res_reg[S_W-1:0];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[l] <= '0;
                    dvd_reg[l] <= '0;
                end
                dvd_reg[0] <= DVD_W'(gain) << (2 * FRAC_BITS);
            end
            P_DIV1:
            begin
                if (cnt_reg == '0)
                begin
                    for (int l = 0; l < LANES; l++)
                        rem_reg[l] <= '0;
                    dvd_reg[0] <= DVD_W'(dvd_step[0][G_W-1:0]) << FRAC_BITS;
                    dvd_reg[1] <= DVD_W'(magx_reg) << UNIT_BITS;
                    dvd_reg[2] <= DVD_W'(magy_reg) << UNIT_BITS;
                end
                else
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        rem_reg[l] <= rem_step[l];
                        dvd_reg[l] <= dvd_step[l];
                    end
                end
            end
            P_DIV2:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[l] <= rem_step[l];
                    dvd_reg[l] <= dvd_step[l];
                end
                if (cnt_reg == '0)
                begin
                    g_reg  <= dvd_step[0][G_W-1:0];
                    ux_reg <= dvd_step[1][UNIT_BITS:0];
                    uy_reg <= dvd_step[2][UNIT_BITS:0];
                end
            end
            P_MUL:
            begin
                prodx_reg <= PROD_W'(ux_reg) * PROD_W'(g_reg);
                prody_reg <= PROD_W'(uy_reg) * PROD_W'(g_reg);
            end
            default: ;
        endcase
    end

    assign pmx    = prodx_reg[PROD_W-1:UNIT_BITS];
    assign pmy    = prody_reg[PROD_W-1:UNIT_BITS];
    assign comp_x = negx_reg ? -$signed(COMP_W'(pmx)) : $signed(COMP_W'(pmx));
    assign comp_y = negy_reg ? -$signed(COMP_W'(pmy)) : $signed(COMP_W'(pmy));
    assign done   = (state_reg == P_FIN);

endmodule

[rtl/core/force_directed_layout_step_core.sv]
// Repulsion-only force-directed layout engine. Node positions (24-bit signed,
// POS_FRAC_BITS fraction bits) sit in a synchronous position RAM with separate
// write and read ports; a load beat writes one node and gives no result. A step
// beat computes, for each node in use, the summed repulsion c*d/dist^3 from
// every other node (old positions throughout), parks the saturated 32-bit
// force in a force RAM, then walks the nodes again applying force*damping/256
// with saturation, writing the positions back and emitting one result beat
// per node in index order, last set on the final one. Each ordered node
// pair occupies the shared pair unit in turn (square, 25-step square root,
// then two rounds of bit-serial division over DVD_W bits, 41 at default
// fraction bits); the next pair is not started until the unit is done. The
// input is taken only while no step is running; a finished result beat waits
// in an output register while the next node is being moved. Config writes
// are always accepted and must only be issued while the block is quiet.
module force_directed_layout_step_core #(
    parameter int MAX_NODES     = 64,
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  req_type,
    input  logic [fdl_pkg::IDX_W-1:0]             node_index,
    input  logic signed [fdl_pkg::POS_W-1:0]      pos_x,
    input  logic signed [fdl_pkg::POS_W-1:0]      pos_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [fdl_pkg::IDX_W-1:0]             out_index,
    output logic signed [fdl_pkg::POS_W-1:0]      out_x,
    output logic signed [fdl_pkg::POS_W-1:0]      out_y,
    output logic                                  last
);
    import fdl_pkg::*;

    localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int WIDE_W = ADDR_W + IDX_W;
    localparam int COMP_W = POS_FRAC_BITS + 18;
    localparam int SUM_W  = COMP_W + ADDR_W + 1;
    localparam int EXT_W  = (SUM_W > 33) ? SUM_W : 33;
    localparam int MP_W   = FORCE_W + DAMP_W;
    localparam int DLT_W  = MP_W - 8;
    localparam int R_W    = DLT_W + 2;

    localparam logic signed [EXT_W-1:0] F_HI = EXT_W'(64'sh7FFF_FFFF);
    localparam logic signed [EXT_W-1:0] F_LO = EXT_W'(-64'sh8000_0000);
    localparam logic signed [R_W-1:0]   P_HI = R_W'(64'sd8388607);
    localparam logic signed [R_W-1:0]   P_LO = R_W'(-64'sd8388608);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RDI  = 10'b0000000010,   // fetch row node
        S_LATI = 10'b0000000100,
        S_RDJ  = 10'b0000001000,   // fetch partner node
        S_LATJ = 10'b0000010000,
        S_PAIR = 10'b0000100000,
        S_WRF  = 10'b0001000000,   // park row force
        S_MRD  = 10'b0010000000,   // move pass
        S_MMUL = 10'b0100000000,
        S_MADD = 10'b1000000000
    } state_t;

    state_t                   state_reg;
    logic [ADDR_W-1:0]        i_reg, j_reg, last_reg;
    logic [COUNT_W-1:0]       node_count_reg;
    logic [GAIN_W-1:0]        repulsion_gain_reg;
    logic [DAMP_W-1:0]        damping_gain_reg;
    logic                     out_valid_reg;

    // storage
    logic [2*POS_W-1:0]       pos_mem   [MAX_NODES];
    logic [2*FORCE_W-1:0]     force_mem [MAX_NODES];
    logic [2*POS_W-1:0]       pos_rd_reg;
    logic [2*FORCE_W-1:0]     force_rd_reg;

    // datapath
    logic signed [POS_W-1:0]  pix_reg, piy_reg;
    logic signed [SUM_W-1:0]  accx_reg, accy_reg;
    logic signed [POS_W-1:0]  posx_reg, posy_reg;
    logic [DLT_W-1:0]         dltx_reg, dlty_reg;
    logic                     negfx_reg, negfy_reg;
    logic [IDX_W-1:0]         out_index_reg;
    logic signed [POS_W-1:0]  out_x_reg, out_y_reg;
    logic                     out_last_reg;

    logic                     load_go, step_go, move_go, idx_ok;
    logic [WIDE_W-1:0]        idx_wide, i_wide;
    logic [CNT_W-1:0]         n_use;
    logic                     pos_we;
    logic [ADDR_W-1:0]        pos_waddr, pos_raddr;
    logic [2*POS_W-1:0]       pos_wdata;
    pair_req_t                pair_req;
    logic                     pair_done;
    logic signed [COMP_W-1:0] comp_x, comp_y;
    logic signed [FORCE_W-1:0] rd_fx, rd_fy;
    logic [FORCE_W-1:0]       mag_fx, mag_fy;
    logic [MP_W-1:0]          mpx, mpy;
    logic signed [R_W-1:0]    rx, ry;
    logic signed [POS_W-1:0]  newx, newy;

    function automatic logic signed [FORCE_W-1:0] sat_force(input logic signed [SUM_W-1:0] a);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(a);
        if (e > F_HI)
            return FORCE_W'(F_HI);
        else if (e < F_LO)
            return FORCE_W'(F_LO);
        return FORCE_W'(e);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [R_W-1:0] a);
        if (a > P_HI)
            return POS_W'(P_HI);
        else if (a < P_LO)
            return POS_W'(P_LO);
        return POS_W'(a);
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign load_go   = in_valid && in_ready && (req_type == REQ_LOAD);
    assign step_go   = in_valid && in_ready && (req_type == REQ_STEP);
    assign move_go   = (state_reg == S_MADD) && (!out_valid_reg || out_ready);

    assign idx_wide  = WIDE_W'(node_index);
    assign i_wide    = WIDE_W'(i_reg);
    assign idx_ok    = (int'(node_index) < MAX_NODES);

    always_comb
    begin
        if (int'(node_count_reg) > MAX_NODES)
            n_use = CNT_W'(MAX_NODES);
        else
            n_use = CNT_W'(node_count_reg);
    end

    // position RAM port steering
    assign pos_raddr = (state_reg == S_RDJ) ? j_reg : i_reg;
    assign pos_we    = (load_go && idx_ok) || move_go;
    assign pos_waddr = move_go ? i_reg : idx_wide[ADDR_W-1:0];
    assign pos_wdata = move_go ? {newx, newy} : {pos_x, pos_y};

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRF)
            force_mem[i_reg] <= {sat_force(accx_reg), sat_force(accy_reg)};
        force_rd_reg <= force_mem[i_reg];
    end

    // pair unit
    assign pair_req.start = (state_reg == S_LATJ);
    assign pair_req.dx    = DIFF_W'(pix_reg) - DIFF_W'($signed(pos_rd_reg[2*POS_W-1:POS_W]));
    assign pair_req.dy    = DIFF_W'(piy_reg) - DIFF_W'($signed(pos_rd_reg[POS_W-1:0]));

    fdl_pair_force #(
        .FRAC_BITS (POS_FRAC_BITS)
    ) u_pair (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (pair_req),
        .gain   (repulsion_gain_reg),
        .done   (pair_done),
        .comp_x (comp_x),
        .comp_y (comp_y)
    );

    // move arithmetic
    assign rd_fx  = force_rd_reg[2*FORCE_W-1:FORCE_W];
    assign rd_fy  = force_rd_reg[FORCE_W-1:0];
    assign mag_fx = rd_fx[FORCE_W-1] ? FORCE_W'(-rd_fx) : FORCE_W'(rd_fx);
    assign mag_fy = rd_fy[FORCE_W-1] ? FORCE_W'(-rd_fy) : FORCE_W'(rd_fy);
    assign mpx    = MP_W'(mag_fx) * MP_W'(damping_gain_reg);
    assign mpy    = MP_W'(mag_fy) * MP_W'(damping_gain_reg);
    assign rx     = negfx_reg ? R_W'(posx_reg) - $signed(R_W'(dltx_reg))
                              : R_W'(posx_reg) + $signed(R_W'(dltx_reg));
    assign ry     = negfy_reg ? R_W'(posy_reg) - $signed(R_W'(dlty_reg))
                              : R_W'(posy_reg) + $signed(R_W'(dlty_reg));
    assign newx   = sat_pos(rx);
    assign newy   = sat_pos(ry);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            i_reg              <= '0;
            j_reg              <= '0;
            last_reg           <= '0;
            out_valid_reg      <= 1'b0;
            node_count_reg     <= NODE_COUNT_RST;
            repulsion_gain_reg <= REPULSION_GAIN_RST;
            damping_gain_reg   <= DAMPING_GAIN_RST;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT:     node_count_reg     <= cfg_data[COUNT_W-1:0];
                    CFG_REPULSION_GAIN: repulsion_gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_DAMPING_GAIN:   damping_gain_reg   <= cfg_data[DAMP_W-1:0];
                    default: ;
                endcase
            end

            if (move_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (step_go && (n_use != '0))
                    begin
                        i_reg     <= '0;
                        last_reg  <= ADDR_W'(n_use - 1'b1);
                        state_reg <= S_RDI;
                    end
                end
                S_RDI:  state_reg <= S_LATI;
                S_LATI:
                begin
                    j_reg     <= '0;
                    state_reg <= S_RDJ;
                end
                S_RDJ:
                begin
                    if (j_reg == i_reg)
                    begin
                        // a node exerts no force on itself
                        if (j_reg == last_reg)
                            state_reg <= S_WRF;
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                    else
                        state_reg <= S_LATJ;
                end
                S_LATJ: state_reg <= S_PAIR;
                S_PAIR:
                begin
                    if (pair_done)
                    begin
                        if (j_reg == last_reg)
                            state_reg <= S_WRF;
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_RDJ;
                        end
                    end
                end
                S_WRF:
                begin
                    if (i_reg == last_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_MRD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_RDI;
                    end
                end
                S_MRD:  state_reg <= S_MMUL;
                S_MMUL: state_reg <= S_MADD;
                S_MADD:
                begin
                    if (move_go)
                    begin
                        if (i_reg == last_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_MRD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LATI)
        begin
            pix_reg  <= $signed(pos_rd_reg[2*POS_W-1:POS_W]);
            piy_reg  <= $signed(pos_rd_reg[POS_W-1:0]);
            accx_reg <= '0;
            accy_reg <= '0;
        end
        else if ((state_reg == S_PAIR) && pair_done)
        begin
            accx_reg <= accx_reg + SUM_W'(comp_x);
            accy_reg <= accy_reg + SUM_W'(comp_y);
        end

        if (state_reg == S_MMUL)
        begin
            posx_reg  <= $signed(pos_rd_reg[2*POS_W-1:POS_W]);
            posy_reg  <= $signed(pos_rd_reg[POS_W-1:0]);
            negfx_reg <= rd_fx[FORCE_W-1];
            negfy_reg <= rd_fy[FORCE_W-1];
            dltx_reg  <= mpx[MP_W-1:8];
            dlty_reg  <= mpy[MP_W-1:8];
        end

        if (move_go)
        begin
            out_index_reg <= i_wide[IDX_W-1:0];
            out_x_reg     <= newx;
            out_y_reg     <= newy;
            out_last_reg  <= (i_reg == last_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign last      = out_last_reg;

`ifndef SYNTHESIS
    a_done_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
        pair_done |-> (state_reg == S_PAIR))
        else $error("pair unit finished outside pair wait");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (i_reg <= last_reg))
        else $error("row index past node count");

    a_to_move: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WRF) && (i_reg == last_reg)) |=> ((state_reg == S_MRD) && (i_reg == '0)))
        else $error("force pass did not hand over to move pass");

    a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (move_go && (i_reg == last_reg)) |=> ((state_reg == S_IDLE) && out_last_reg && out_valid_reg))
        else $error("final beat not marked last");
`endif

endmodule
